FILE: design/adp_pkg.sv
// ----------------------------------------------------------------------------
// adp_pkg
// Widths and fixed constants shared by the deadline pacer and its channels.
// ----------------------------------------------------------------------------
package adp_pkg;

   localparam int NOW_W    = 63;   // now_ns, wait_ns
   localparam int TIME_W   = 64;   // deadline and adder width
   localparam int FRAMES_W = 20;   // frames_served port
   localparam int RATE_W   = 19;   // sample_rate
   localparam int LAG_W    = 30;   // max_lag_ns register
   localparam int NS_W     = 30;   // bits of one second in ns

   localparam logic [TIME_W-1:0] NS_PER_SEC   = 64'd1000000000;
   localparam logic [LAG_W-1:0]  LAG_RESET_NS = 30'd50000000;

   // pace request modes
   localparam logic MODE_PACE  = 1'b0;
   localparam logic MODE_RESET = 1'b1;

endpackage

FILE: design/adp_ifs.sv
// ----------------------------------------------------------------------------
// adp channel interfaces
// Valid/ready word channels for pace requests, responses and the CSR write.
// ----------------------------------------------------------------------------
interface adp_req_if;
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic [adp_pkg::NOW_W-1:0]    now_ns;
   logic [adp_pkg::FRAMES_W-1:0] frames_served;
   logic [adp_pkg::RATE_W-1:0]   sample_rate;

   modport source (output valid, mode, now_ns, frames_served, sample_rate, input ready);
   modport sink   (input valid, mode, now_ns, frames_served, sample_rate, output ready);
endinterface

interface adp_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [adp_pkg::NOW_W-1:0] wait_ns;
   logic                      baseline_reset;
   logic                      ignored;

   modport source (output valid, wait_ns, baseline_reset, ignored, input ready);
   modport sink   (input valid, wait_ns, baseline_reset, ignored, output ready);
endinterface

interface adp_csr_if;
   logic                      valid;
   logic                      ready;
   logic [adp_pkg::LAG_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: design/audio_deadline_pacer_top.sv
// ----------------------------------------------------------------------------
// audio_deadline_pacer_top
// Paces audio delivery: tracks a deadline and tells the caller how long to wait.
// ----------------------------------------------------------------------------
// Usage:
//   req_if  - one word per audio buffer: mode, now_ns, frames_served,
//             sample_rate. Taken only while the sequencer is idle.
//   rsp_if  - exactly one word per request: wait_ns, baseline_reset, ignored.
//   csr_if  - writes max_lag_ns; always ready, write only while idle.
// Sequence: a pace request steps through F = min(FRAME_BITS, 20) shift-add
//   steps that form frames*1e9, then F+30 restoring steps that divide it by
//   the rate, then add, gap and, if the gap is not positive, lag and compare,
//   all on the same 64-bit adder. A reset request or a zero rate goes straight
//   to the response. A new request is taken only after the previous result
//   has left the sequencer; the single shared adder serialises the steps.
// Reset: clears started, last rate, deadline and the response valid flag;
//   max_lag_ns returns to 50 ms.
// Stall: the response sits in an output register. A new request is taken while
//   it waits; a finished result then holds in the sequencer until the
//   receiver drains the older word.
// ----------------------------------------------------------------------------
module audio_deadline_pacer_top #(
   parameter int FRAME_BITS = 20
) (
   input  logic   clock,
   input  logic   reset,
   adp_req_if.sink   req_if,
   adp_rsp_if.source rsp_if,
   adp_csr_if.sink   csr_if
);

   localparam int TW     = adp_pkg::TIME_W;
   localparam int RW     = adp_pkg::RATE_W;
   // frames bits that survive the FRAME_BITS mask
   localparam int FW     = (FRAME_BITS < adp_pkg::FRAMES_W) ? FRAME_BITS : adp_pkg::FRAMES_W;
   // width of frames * 1e9
   localparam int PROD_W = FW + adp_pkg::NS_W;
   localparam int CNT_W  = $clog2(PROD_W + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_DIV, ST_ADD, ST_GAP, ST_LAG, ST_CMP, ST_FINISH
   } state_type;

   state_type                   state_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic [TW-1:0]               acc_ff;      // product, then quotient, then lag
   logic [RW-1:0]               rem_ff;
   logic [FW-1:0]               frames_ff;
   logic [RW-1:0]               rate_ff;
   logic [adp_pkg::NOW_W-1:0]   now_ff;

   logic                        started_ff;
   logic [RW-1:0]               last_rate_ff;
   logic [TW-1:0]               deadline_ff;
   logic [adp_pkg::LAG_W-1:0]   max_lag_ff;

   logic [adp_pkg::NOW_W-1:0]   pend_wait_ff;
   logic                        pend_reset_ff;
   logic                        pend_ign_ff;

   logic                        rsp_valid_ff;
   logic [adp_pkg::NOW_W-1:0]   rsp_wait_ff;
   logic                        rsp_reset_ff;
   logic                        rsp_ign_ff;

   // shared adder: sum = a + b, or a - b with carry = no borrow
   logic [TW-1:0] op_a;
   logic [TW-1:0] op_b;
   logic          op_sub;
   logic [TW:0]   sum;
   logic          carry;
   logic          qbit;
   logic          req_fire;
   logic          rsp_load;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   // a finished word moves into the output register once it is free
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_if.ready);

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.wait_ns        = rsp_wait_ff;
   assign rsp_if.baseline_reset = rsp_reset_ff;
   assign rsp_if.ignored        = rsp_ign_ff;

   // operand select for the one adder
   always_comb begin
      op_a   = '0;
      op_b   = '0;
      op_sub = 1'b0;
      unique case (state_ff)
         ST_MUL: begin
            // MSB-first shift-add of frames * 1e9
            op_a = {acc_ff[TW-2:0], 1'b0};
            op_b = frames_ff[FW-1] ? adp_pkg::NS_PER_SEC : '0;
         end
         ST_DIV: begin
            // restoring step: shift in next dividend bit, try subtracting rate
            op_a   = {{(TW-RW-1){1'b0}}, rem_ff, acc_ff[PROD_W-1]};
            op_b   = {{(TW-RW){1'b0}}, rate_ff};
            op_sub = 1'b1;
         end
         ST_ADD: begin
            op_a = deadline_ff;
            op_b = acc_ff;
         end
         ST_GAP: begin
            op_a   = deadline_ff;
            op_b   = {1'b0, now_ff};
            op_sub = 1'b1;
         end
         ST_LAG: begin
            op_a   = {1'b0, now_ff};
            op_b   = deadline_ff;
            op_sub = 1'b1;
         end
         ST_CMP: begin
            // carry clear means lag > max_lag
            op_a   = {{(TW-adp_pkg::LAG_W){1'b0}}, max_lag_ff};
            op_b   = acc_ff;
            op_sub = 1'b1;
         end
         default: begin
            op_a   = '0;
            op_b   = '0;
            op_sub = 1'b0;
         end
      endcase
   end

   assign sum   = {1'b0, op_a} + {1'b0, op_b ^ {TW{op_sub}}} + {{TW{1'b0}}, op_sub};
   assign carry = sum[TW];
   assign qbit  = carry;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         started_ff    <= 1'b0;
         last_rate_ff  <= '0;
         deadline_ff   <= '0;
         max_lag_ff    <= adp_pkg::LAG_RESET_NS;
      end else begin
         if (csr_if.valid) begin
            max_lag_ff <= csr_if.data;
         end

         // load a finished word, or drain the output register
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  pend_wait_ff  <= '0;
                  pend_reset_ff <= 1'b0;
                  pend_ign_ff   <= 1'b0;
                  priority if (req_if.mode == adp_pkg::MODE_RESET) begin
                     started_ff <= 1'b0;
                     state_ff   <= ST_FINISH;
                  end else if (req_if.sample_rate == '0) begin
                     pend_ign_ff <= 1'b1;
                     state_ff    <= ST_FINISH;
                  end else begin
                     if (!started_ff || (last_rate_ff != req_if.sample_rate)) begin
                        started_ff   <= 1'b1;
                        last_rate_ff <= req_if.sample_rate;
                        deadline_ff  <= {1'b0, req_if.now_ns};
                     end
                     now_ff    <= req_if.now_ns;
                     frames_ff <= req_if.frames_served[FW-1:0];
                     rate_ff   <= req_if.sample_rate;
                     acc_ff    <= '0;
                     cnt_ff    <= CNT_W'(FW - 1);
                     state_ff  <= ST_MUL;
                  end
               end
            end
            ST_MUL: begin
               acc_ff    <= sum[TW-1:0];
               frames_ff <= frames_ff << 1;
               if (cnt_ff == '0) begin
                  rem_ff   <= '0;
                  cnt_ff   <= CNT_W'(PROD_W - 1);
                  state_ff <= ST_DIV;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            ST_DIV: begin
               // remainder stays below rate, so 19 bits hold it
               rem_ff <= carry ? sum[RW-1:0] : op_a[RW-1:0];
               acc_ff <= {{(TW-PROD_W){1'b0}}, acc_ff[PROD_W-2:0], qbit};
               if (cnt_ff == '0) begin
                  state_ff <= ST_ADD;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            ST_ADD: begin
               deadline_ff <= sum[TW-1:0];
               state_ff    <= ST_GAP;
            end
            ST_GAP: begin
               // positive gap: wait; otherwise check the lag
               if ((sum[TW-1:0] != '0) && !sum[TW-1]) begin
                  pend_wait_ff <= sum[adp_pkg::NOW_W-1:0];
                  state_ff     <= ST_FINISH;
               end else begin
                  state_ff <= ST_LAG;
               end
            end
            ST_LAG: begin
               acc_ff   <= sum[TW-1:0];
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               if (!carry) begin
                  deadline_ff   <= {1'b0, now_ff};
                  pend_reset_ff <= 1'b1;
               end
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               // hold until the output register is free
               if (rsp_load) begin
                  rsp_wait_ff  <= pend_wait_ff;
                  rsp_reset_ff <= pend_reset_ff;
                  rsp_ign_ff   <= pend_ign_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // a taken request closes the input until its result is out
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_if.ready)
      else $error("request accepted while sequencer busy");

   // a pace request with a nonzero rate leaves the pacer started
   a_started_after_pace: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_if.mode == adp_pkg::MODE_PACE) && (req_if.sample_rate != '0))
      |=> started_ff)
      else $error("started flag not set by pace request");

   // an ignored request reports neither wait nor baseline reset
   a_ignored_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ign_ff) |-> ((rsp_wait_ff == '0) && !rsp_reset_ff))
      else $error("ignored response carries wait or reset");

   // a baseline reset never comes with a wait
   a_reset_no_wait: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_reset_ff) |-> (rsp_wait_ff == '0))
      else $error("baseline reset with nonzero wait");

   // a stalled response word holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |=> (rsp_valid_ff && $stable(rsp_wait_ff)))
      else $error("stalled response changed");

endmodule
